### hw/rtl/rne_pkg.sv
// rne_pkg: shared types and the numeral symbol table for the roman numeral encoder
// used by rne_ctrl, rne_dp and roman_numeral_encoder; depends on nothing
package rne_pkg;

   localparam int NUM_W     = 12;
   localparam int LETTER_W  = 8;
   localparam int SYM_COUNT = 13;
   localparam int SYM_IDX_W = $clog2(SYM_COUNT);

   localparam logic [NUM_W-1:0] MAX_VALUE = 12'd3999;
   localparam logic [LETTER_W-1:0] NO_LETTER = 8'h00;

   // greedy table, largest first; two-letter entries are the subtractive forms
   localparam logic [NUM_W-1:0] SYM_VALUE [SYM_COUNT] = '{
      12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
      12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
   };

   // M CM D CD C XC L XL X IX V IV I
   localparam logic [LETTER_W-1:0] SYM_FIRST [SYM_COUNT] = '{
      8'h4D, 8'h43, 8'h44, 8'h43, 8'h43, 8'h58, 8'h4C,
      8'h58, 8'h58, 8'h49, 8'h56, 8'h49, 8'h49
   };

   localparam logic [LETTER_W-1:0] SYM_SECOND [SYM_COUNT] = '{
      8'h00, 8'h4D, 8'h00, 8'h44, 8'h00, 8'h43, 8'h00,
      8'h4C, 8'h00, 8'h58, 8'h00, 8'h56, 8'h00
   };

   localparam logic [SYM_COUNT-1:0] SYM_PAIR = 13'b0101010101010;

   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_sts_type;

endpackage

### hw/rtl/rne_ctrl.sv
// rne_ctrl: two-state controller that sequences one request through the datapath
// depends on rne_pkg
module rne_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output rne_pkg::dp_cmd_type cmd,
   input  rne_pkg::dp_sts_type sts
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (sts.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy     = (state_ff == ST_RUN);
   assign cmd.load = start && (state_ff == ST_IDLE);
   assign cmd.step = (state_ff == ST_RUN);

endmodule

### hw/rtl/rne_dp.sv
// rne_dp: remainder register, greedy symbol select and registered letter output
// depends on rne_pkg
module rne_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  rne_pkg::dp_cmd_type         cmd,
   output rne_pkg::dp_sts_type         sts,
   input  logic [rne_pkg::NUM_W-1:0]   number_in,
   output logic                        rsp_valid,
   output logic [rne_pkg::LETTER_W-1:0] rsp_letter,
   output logic                        rsp_bad_value,
   output logic                        rsp_last_letter
);

   logic [rne_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic                         bad_ff, bad_in;
   logic                         half_ff, half_in;
   logic                         valid_ff;
   logic [rne_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic                         badout_ff;
   logic                         last_ff, last_in;
   logic [rne_pkg::SYM_IDX_W-1:0] sel;

   // first table entry that fits in the remainder
   always_comb begin
      sel = '0;
      for (int i = rne_pkg::SYM_COUNT - 1; i >= 0; i--) begin
         if (rem_ff >= rne_pkg::SYM_VALUE[i]) sel = rne_pkg::SYM_IDX_W'(i);
      end
   end

   always_comb begin
      rem_in    = rem_ff;
      bad_in    = bad_ff;
      half_in   = half_ff;
      letter_in = rne_pkg::NO_LETTER;
      last_in   = 1'b0;
      priority if (cmd.load) begin
         rem_in  = number_in;
         bad_in  = (number_in == '0) || (number_in > rne_pkg::MAX_VALUE);
         half_in = 1'b0;
      end else if (cmd.step && bad_ff) begin
         last_in = 1'b1;
      end else if (cmd.step && half_ff) begin
         // second letter of a subtractive pair
         letter_in = rne_pkg::SYM_SECOND[sel];
         rem_in    = rem_ff - rne_pkg::SYM_VALUE[sel];
         last_in   = (rem_ff == rne_pkg::SYM_VALUE[sel]);
         half_in   = 1'b0;
      end else if (cmd.step) begin
         letter_in = rne_pkg::SYM_FIRST[sel];
         if (rne_pkg::SYM_PAIR[sel]) begin
            half_in = 1'b1;
         end else begin
            rem_in  = rem_ff - rne_pkg::SYM_VALUE[sel];
            last_in = (rem_ff == rne_pkg::SYM_VALUE[sel]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= cmd.step;
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bad_ff  <= bad_in;
      half_ff <= half_in;
      if (cmd.step) begin
         letter_ff <= letter_in;
         badout_ff <= bad_ff;
         last_ff   <= last_in;
      end
   end

   assign sts.last        = cmd.step && last_in;
   assign rsp_valid       = valid_ff;
   assign rsp_letter      = letter_ff;
   assign rsp_bad_value   = badout_ff;
   assign rsp_last_letter = last_ff;

endmodule

### hw/rtl/roman_numeral_encoder.sv
// roman_numeral_encoder: top level, converts 1..3999 to a run of ascii numeral letters
// depends on rne_pkg, rne_ctrl and rne_dp
// a request is taken when start is high and busy is low; letters follow one per cycle
// the request is loaded into the remainder register and each letter then goes through the
// registered letter output, n letters (1 to 15) in all; the next request is taken while the
// last letter shows; the greedy select loop gives one letter a cycle
// synchronous reset returns the controller to idle and drops rsp_valid; the receiver never stalls
module roman_numeral_encoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rne_pkg::NUM_W-1:0]    req_number_in,
   output logic                         rsp_valid,
   output logic [rne_pkg::LETTER_W-1:0] rsp_letter,
   output logic                         rsp_bad_value,
   output logic                         rsp_last_letter
);

   rne_pkg::dp_cmd_type cmd;
   rne_pkg::dp_sts_type sts;

   rne_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   rne_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .number_in       (req_number_in),
      .rsp_valid       (rsp_valid),
      .rsp_letter      (rsp_letter),
      .rsp_bad_value   (rsp_bad_value),
      .rsp_last_letter (rsp_last_letter)
   );

endmodule
